// ===== rtl/set_assoc_cache_tag_lookup_core_macros.svh =====
// Assertion macros used by the cache tag lookup top level.
`ifndef SET_ASSOC_CACHE_TAG_LOOKUP_CORE_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_LOOKUP_CORE_MACROS_SVH

// Plain property, sampled on clock, ignored while reset is high.
`define SCATL_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("scatl assertion failed");

// Cause in one cycle, effect in the next.
`define SCATL_ASSERT_NEXT(lbl, cause, effect) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("scatl assertion failed");

`endif

// ===== rtl/scatl_pkg.sv =====
// Package of the cache tag lookup: default geometry, counter limit, helpers.
`timescale 1ns / 1ps
package scatl_pkg;

   localparam int WAYS_DEF        = 4;
   localparam int SETS_DEF        = 64;
   localparam int BLOCK_BYTES_DEF = 64;
   localparam int ADDR_BITS_DEF   = 32;

   localparam int          ADDR_PORT_W = 32;
   localparam logic [31:0] CNT_MAX     = 32'hFFFF_FFFF;

   // floor(log2(v)), zero for v <= 1; used at elaboration only
   function automatic int floor_log2(input longint v);
      int     n;
      longint x;
      n = 0;
      x = v;
      while (x > 1) begin
         x = x >> 1;
         n = n + 1;
      end
      return n;
   endfunction

   // bits needed to number 'n' items, at least one
   function automatic int index_width(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

// ===== rtl/scatl_line_store.sv =====
// Line store: tag and dirty memory per set, valid flip-flops per way.
`timescale 1ns / 1ps
module scatl_line_store #(
   parameter int SETS  = scatl_pkg::SETS_DEF,
   parameter int WAYS  = scatl_pkg::WAYS_DEF,
   parameter int TAG_W = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [scatl_pkg::index_width(SETS)-1:0] rd_set,
   output logic [WAYS*(TAG_W+1)-1:0]             rd_line,
   output logic [WAYS-1:0]                       rd_valid,
   input  logic                                  wr_en,
   input  logic [scatl_pkg::index_width(SETS)-1:0] wr_set,
   input  logic [WAYS*(TAG_W+1)-1:0]             wr_line,
   input  logic [WAYS-1:0]                       wr_valid
);

   localparam int LINE_W = WAYS * (TAG_W + 1);

   logic [LINE_W-1:0] line_mem [SETS];
   logic [WAYS-1:0]   valid_ff [SETS];
   logic [LINE_W-1:0] rd_line_ff;
   logic [WAYS-1:0]   rd_valid_ff;

   // memory: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_set] <= wr_line;
      end
      if (rd_en) begin
         rd_line_ff <= line_mem[rd_set];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s] <= '0;
         end
         rd_valid_ff <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_set] <= wr_valid;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_set];
         end
      end
   end

   assign rd_line  = rd_line_ff;
   assign rd_valid = rd_valid_ff;

endmodule

// ===== rtl/scatl_repl_store.sv =====
// Replacement store: recency list and fifo pointer memory per set.
`timescale 1ns / 1ps
module scatl_repl_store #(
   parameter int SETS  = scatl_pkg::SETS_DEF,
   parameter int WAYS  = scatl_pkg::WAYS_DEF,
   parameter int WAY_W = 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rd_en,
   input  logic [scatl_pkg::index_width(SETS)-1:0] rd_set,
   output logic [(WAYS+1)*WAY_W-1:0]             rd_word,
   input  logic                                  wr_en,
   input  logic [scatl_pkg::index_width(SETS)-1:0] wr_set,
   input  logic [(WAYS+1)*WAY_W-1:0]             wr_word
);

   localparam int WORD_W = (WAYS + 1) * WAY_W;

   logic [WORD_W-1:0] pol_mem [SETS];
   logic              init_ff [SETS];
   logic [WORD_W-1:0] rd_word_ff;
   logic              rd_init_ff;
   logic [WORD_W-1:0] reset_word;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         pol_mem[wr_set] <= wr_word;
      end
      if (rd_en) begin
         rd_word_ff <= pol_mem[rd_set];
      end
   end

   // a set never written reads as its reset policy state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SETS; s++) begin
            init_ff[s] <= 1'b0;
         end
         rd_init_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            init_ff[wr_set] <= 1'b1;
         end
         if (rd_en) begin
            rd_init_ff <= init_ff[rd_set];
         end
      end
   end

   // recency ways 0..WAYS-1, most recent first; pointer zero
   always_comb begin
      reset_word = '0;
      for (int i = 0; i < WAYS; i++) begin
         reset_word[i*WAY_W +: WAY_W] = WAY_W'(i);
      end
   end

   assign rd_word = rd_init_ff ? rd_word_ff : reset_word;

endmodule

// ===== rtl/scatl_lookup.sv =====
// Tag compare, victim choice and line / policy update for one set.
`timescale 1ns / 1ps
module scatl_lookup #(
   parameter int WAYS  = scatl_pkg::WAYS_DEF,
   parameter int WAY_W = 2,
   parameter int TAG_W = 20
) (
   input  logic [TAG_W-1:0]              tag,
   input  logic                          is_write,
   input  logic                          replace_lru,
   input  logic [WAYS*(TAG_W+1)-1:0]     line_old,
   input  logic [WAYS-1:0]               valid_old,
   input  logic [(WAYS+1)*WAY_W-1:0]     pol_old,
   output logic                          hit,
   output logic [WAY_W-1:0]              target,
   output logic [WAYS*(TAG_W+1)-1:0]     line_new,
   output logic [WAYS-1:0]               valid_new,
   output logic [(WAYS+1)*WAY_W-1:0]     pol_new
);

   localparam int LW = TAG_W + 1;

   logic [WAY_W-1:0] rec     [WAYS];
   logic [WAY_W-1:0] rec_new [WAYS];
   logic [WAY_W-1:0] ptr;
   logic [WAY_W-1:0] hit_way;
   logic [WAY_W-1:0] free_way;
   logic [WAY_W-1:0] victim;
   logic [WAY_W-1:0] pos;
   logic             free_found;
   logic             pos_found;

   always_comb begin
      for (int i = 0; i < WAYS; i++) begin
         rec[i] = pol_old[i*WAY_W +: WAY_W];
      end
      ptr = pol_old[WAYS*WAY_W +: WAY_W];

      // first valid way holding the tag
      hit     = 1'b0;
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!hit && valid_old[w] && (line_old[w*LW +: TAG_W] == tag)) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end

      // lowest invalid way
      free_found = 1'b0;
      free_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!free_found && !valid_old[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end

      victim = replace_lru ? rec[WAYS-1] : ptr;
      if (32'(victim) >= WAYS) begin
         victim = '0;
      end

      if (hit) begin
         target = hit_way;
      end else if (free_found) begin
         target = free_way;
      end else begin
         target = victim;
      end

      // move target to the front of the recency list
      pos       = WAY_W'(WAYS - 1);
      pos_found = 1'b0;
      for (int i = 0; i < WAYS; i++) begin
         if (!pos_found && (rec[i] == target)) begin
            pos_found = 1'b1;
            pos       = WAY_W'(i);
         end
      end
      rec_new[0] = target;
      for (int i = 1; i < WAYS; i++) begin
         rec_new[i] = (i <= 32'(pos)) ? rec[i-1] : rec[i];
      end

      // only the selected policy's state moves
      pol_new = pol_old;
      if (replace_lru) begin
         for (int i = 0; i < WAYS; i++) begin
            pol_new[i*WAY_W +: WAY_W] = rec_new[i];
         end
      end else if (!hit) begin
         pol_new[WAYS*WAY_W +: WAY_W] = (32'(ptr) == WAYS - 1) ? '0 : ptr + 1'b1;
      end

      line_new  = line_old;
      valid_new = valid_old;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == target) begin
            if (hit) begin
               if (is_write) begin
                  line_new[w*LW + TAG_W] = 1'b1;
               end
            end else begin
               line_new[w*LW +: TAG_W] = tag;
               line_new[w*LW + TAG_W]  = is_write;
               valid_new[w]            = 1'b1;
            end
         end
      end
   end

endmodule

// ===== rtl/set_assoc_cache_tag_lookup_core.sv =====
// Top level of the set-associative cache tag lookup with LRU / FIFO replacement.
// Flow: an accepted req item moves to ST_LOOK while the set's line and policy memories
// are read; ST_LOOK writes them back and loads the result register, and a stalled result
// holds the next lookup in ST_LOOK. A new item is accepted only back in ST_IDLE.
// Reset: synchronous; valid bits and per-set policy init flags clear directly,
// no clearing pass. Tag memory content is undefined until a line is filled.
`timescale 1ns / 1ps
`include "set_assoc_cache_tag_lookup_core_macros.svh"
module set_assoc_cache_tag_lookup_core #(
   parameter int WAYS        = scatl_pkg::WAYS_DEF,
   parameter int SETS        = scatl_pkg::SETS_DEF,
   parameter int BLOCK_BYTES = scatl_pkg::BLOCK_BYTES_DEF,
   parameter int ADDR_BITS   = scatl_pkg::ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request item
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] address
   input  logic        req_tuser,   // [0] is_write
   // result item
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [1:0] way, [33:2] hit_total, [65:34] miss_total, zero fill
   output logic        rsp_tuser,   // [0] hit
   // replacement policy register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // [0] replace_lru
);

   // address split
   localparam int OB      = scatl_pkg::floor_log2(longint'(BLOCK_BYTES));
   localparam int IB      = scatl_pkg::floor_log2(longint'(SETS));
   localparam int AW      = (ADDR_BITS < scatl_pkg::ADDR_PORT_W) ? ADDR_BITS
                                                                 : scatl_pkg::ADDR_PORT_W;
   localparam int TAG_LSB = OB + IB;
   localparam int TAG_W   = (AW - TAG_LSB > 0) ? AW - TAG_LSB : 1;
   localparam int SET_W   = scatl_pkg::index_width(SETS);
   localparam int WAY_W   = scatl_pkg::index_width(WAYS);
   localparam int LINE_W  = WAYS * (TAG_W + 1);
   localparam int POL_W   = (WAYS + 1) * WAY_W;

   localparam logic [31:0] ADDR_MASK = (AW >= 32) ? 32'hFFFF_FFFF
                                                  : 32'((64'd1 << AW) - 64'd1);
   localparam logic [31:0] SET_MASK  = 32'((64'd1 << IB) - 64'd1);
   localparam logic [31:0] SET_LAST  = 32'(SETS - 1);

   typedef enum logic {
      ST_IDLE,
      ST_LOOK
   } state_type;

   state_type         state_ff;
   logic              replace_lru_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic [SET_W-1:0]  set_ff;
   logic              wr_ff;
   logic              rsp_valid_ff;
   logic              rsp_hit_ff;
   logic [1:0]        rsp_way_ff;
   logic [31:0]       hit_cnt_ff;
   logic [31:0]       miss_cnt_ff;

   logic              req_fire;
   logic              out_free;
   logic              look_done;
   logic [31:0]       addr_m;
   logic [31:0]       tag_full;
   logic [31:0]       set_raw;
   logic [SET_W-1:0]  set_in;
   logic [TAG_W-1:0]  tag_in;

   logic [LINE_W-1:0] line_old;
   logic [WAYS-1:0]   valid_old;
   logic [POL_W-1:0]  pol_old;
   logic              hit;
   logic [WAY_W-1:0]  target;
   logic [LINE_W-1:0] line_new;
   logic [WAYS-1:0]   valid_new;
   logic [POL_W-1:0]  pol_new;

   // one item in the lookup at a time; the output register frees the request side
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign look_done  = (state_ff == ST_LOOK) && out_free;

   // split the masked address into set index and tag; an out of range set clamps
   always_comb begin
      addr_m   = req_tdata & ADDR_MASK;
      tag_full = addr_m >> TAG_LSB;
      set_raw  = (addr_m >> OB) & SET_MASK;
      tag_in   = tag_full[TAG_W-1:0];
      if (set_raw > SET_LAST) begin
         set_in = SET_LAST[SET_W-1:0];
      end else begin
         set_in = set_raw[SET_W-1:0];
      end
   end

   scatl_line_store #(
      .SETS  (SETS),
      .WAYS  (WAYS),
      .TAG_W (TAG_W)
   ) u_line_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (req_fire),
      .rd_set   (set_in),
      .rd_line  (line_old),
      .rd_valid (valid_old),
      .wr_en    (look_done),
      .wr_set   (set_ff),
      .wr_line  (line_new),
      .wr_valid (valid_new)
   );

   scatl_repl_store #(
      .SETS  (SETS),
      .WAYS  (WAYS),
      .WAY_W (WAY_W)
   ) u_repl_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_set  (set_in),
      .rd_word (pol_old),
      .wr_en   (look_done),
      .wr_set  (set_ff),
      .wr_word (pol_new)
   );

   scatl_lookup #(
      .WAYS  (WAYS),
      .WAY_W (WAY_W),
      .TAG_W (TAG_W)
   ) u_lookup (
      .tag         (tag_ff),
      .is_write    (wr_ff),
      .replace_lru (replace_lru_ff),
      .line_old    (line_old),
      .valid_old   (valid_old),
      .pol_old     (pol_old),
      .hit         (hit),
      .target      (target),
      .line_new    (line_new),
      .valid_new   (valid_new),
      .pol_new     (pol_new)
   );

   // request capture, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         tag_ff <= tag_in;
         set_ff <= set_in;
         wr_ff  <= req_tuser;
      end
   end

   // sequencer, counters and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
      end else begin
         // a result taken in the same cycle as a new one loads stays valid
         if (rsp_valid_ff && rsp_tready && !look_done) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  state_ff <= ST_LOOK;
               end
            end
            ST_LOOK: begin
               // memories hold their read data while the result side stalls
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_hit_ff   <= hit;
                  rsp_way_ff   <= 2'(target);
                  if (hit) begin
                     if (hit_cnt_ff != scatl_pkg::CNT_MAX) begin
                        hit_cnt_ff <= hit_cnt_ff + 32'd1;
                     end
                  end else begin
                     if (miss_cnt_ff != scatl_pkg::CNT_MAX) begin
                        miss_cnt_ff <= miss_cnt_ff + 32'd1;
                     end
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // policy register, written only while idle
   assign csr_ready = (state_ff == ST_IDLE);
   always_ff @(posedge clock) begin
      if (reset) begin
         replace_lru_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         replace_lru_ff <= csr_data;
      end
   end

   // counters change only when a result loads, so they sit on the bus directly
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {6'b0, miss_cnt_ff, hit_cnt_ff, rsp_way_ff};

   // no second item enters while one is in the lookup
   `SCATL_ASSERT_NEXT(a_one_in_flight, req_fire, !req_tready)
   // a finished lookup always lands in the result register
   `SCATL_ASSERT_NEXT(a_result_loads, look_done, rsp_tvalid)
   // every result has been counted as a hit or a miss
   `SCATL_ASSERT(a_counted, !rsp_tvalid || (hit_cnt_ff != 32'd0) || (miss_cnt_ff != 32'd0))

endmodule
